// File: design/gfdp_pkg.sv
// ----------------------------------------------------------------------------
// gfdp_pkg
// Shared types and constants for the GIF frame delay patcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gfdp_pkg;

  localparam int WinLen   = 9;            // bytes in one scan window
  localparam int HoldLen  = WinLen - 1;   // bytes held between beats
  localparam int HdrLen   = 6;
  localparam int FillW    = 4;            // holds 0..HoldLen
  localparam int QDepth   = WinLen + 1;   // a full flush plus one waiting beat
  localparam int QLevelW  = 4;            // holds 0..QDepth
  localparam int DelayW   = 16;
  localparam int CfgIdxW  = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinDelay  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegReplDelay = 1'b1;

  localparam logic [DelayW-1:0] MinDelayRst  = 16'd2;
  localparam logic [DelayW-1:0] ReplDelayRst = 16'd10;

  // Byte 0 sits in the low lane
  localparam logic [HdrLen-1:0][7:0] Gif87a = {8'h61, 8'h37, 8'h38, 8'h46, 8'h49, 8'h47};
  localparam logic [HdrLen-1:0][7:0] Gif89a = {8'h61, 8'h39, 8'h38, 8'h46, 8'h49, 8'h47};

  // Graphic control extension intro: 00 21 F9 04, terminator at offset 8
  localparam logic [3:0][7:0] GceMarker = {8'h04, 8'hF9, 8'h21, 8'h00};
  localparam logic [7:0]      GceTerm   = 8'h00;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       patched;
  } beat_t;

  // Results raised by one input beat, oldest in lane 0
  typedef struct packed {
    beat_t [WinLen-1:0] beats;
    logic  [FillW-1:0]  count;
  } burst_t;

endpackage

`default_nettype wire

// File: design/gif_frame_delay_patcher_core.sv
// ----------------------------------------------------------------------------
// gif_frame_delay_patcher_core
// Streams a file through a 9-byte window and rewrites short GIF frame delays.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -------------------------------------
//   in       in_valid / in_stall    data_byte[7:0], last_byte
//   out      out_valid / out_stall  out_byte[7:0], out_last, was_patched
//   cfg      cfg_write_en           cfg_index[0], cfg_data[15:0]
//
// One input beat a cycle while in_stall is low. The first eight bytes of a file
// fill the window and raise no output; from then on each input beat yields one
// output beat through the result queue. The final byte flushes up to nine
// beats, which the queue sends at one per cycle while out_stall is low; input
// stalls while two or more beats are queued. Reset is synchronous; it clears
// the file state and loads the delay registers with 2 and 10.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_frame_delay_patcher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // output byte stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             was_patched,
  // register writes
  input  wire logic                         cfg_write_en,
  input  wire logic [gfdp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [gfdp_pkg::DelayW-1:0]  cfg_data
);

  logic [gfdp_pkg::DelayW-1:0]  min_delay;
  logic [gfdp_pkg::DelayW-1:0]  replacement_delay;
  logic                         accept;
  gfdp_pkg::burst_t             burst;
  gfdp_pkg::beat_t              head;
  logic [gfdp_pkg::QLevelW-1:0] level;

  // Delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay         <= gfdp_pkg::MinDelayRst;
      replacement_delay <= gfdp_pkg::ReplDelayRst;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        gfdp_pkg::RegMinDelay:  min_delay         <= cfg_data;
        gfdp_pkg::RegReplDelay: replacement_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Room for a whole flush as long as at most one beat waits
  assign in_stall = (level >= gfdp_pkg::QLevelW'(2));
  assign accept   = in_valid && !in_stall;

  gfdp_window u_window (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .min_delay         (min_delay),
    .replacement_delay (replacement_delay),
    .burst             (burst)
  );

  gfdp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .level     (level)
  );

  assign out_byte    = head.data;
  assign out_last    = head.last;
  assign was_patched = head.patched;

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= gfdp_pkg::QLevelW'(gfdp_pkg::QDepth))
    else $error("result queue overfilled");

  // A file end always leaves something to send
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> out_valid)
    else $error("final byte raised no output");

  // Input stalls only on a backed-up queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty queue");

  // The newest byte of a file is never a rewritten delay byte
  a_last_unpatched: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> !was_patched)
    else $error("final byte marked as patched");

endmodule

`default_nettype wire

// File: design/gfdp_window.sv
// ----------------------------------------------------------------------------
// gfdp_window
// Holding window, header check, delay test and rewrite for one input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gfdp_window (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  input  wire logic [gfdp_pkg::DelayW-1:0] min_delay,
  input  wire logic [gfdp_pkg::DelayW-1:0] replacement_delay,
  output gfdp_pkg::burst_t                 burst
);

  logic [gfdp_pkg::HoldLen-1:0][7:0] win;
  logic [gfdp_pkg::HoldLen-1:0]      mark;
  logic [gfdp_pkg::FillW-1:0]        fill;
  logic                              header_ok;
  logic                              header_checked;
  logic                              scan_stopped;

  logic [gfdp_pkg::WinLen-1:0][7:0]  w9;
  logic [gfdp_pkg::WinLen-1:0]       m9;
  logic [gfdp_pkg::WinLen-1:0][7:0]  p9;
  logic [gfdp_pkg::WinLen-1:0]       pm9;
  logic                              full;
  logic                              hdr_now;
  logic                              hdr_eff;
  logic                              marker_hit;
  logic [gfdp_pkg::DelayW-1:0]       delay;
  logic                              hit;
  logic                              over;

  // Window as seen with the incoming byte placed after the held ones
  always_comb begin
    for (int i = 0; i < gfdp_pkg::WinLen; i++) begin
      if (i < gfdp_pkg::HoldLen && gfdp_pkg::FillW'(i) < fill) begin
        w9[i] = win[i];
        m9[i] = mark[i];
      end else begin
        w9[i] = data_byte;
        m9[i] = 1'b0;
      end
    end
  end

  assign full       = (fill == gfdp_pkg::FillW'(gfdp_pkg::HoldLen));
  assign hdr_now    = (w9[gfdp_pkg::HdrLen-1:0] == gfdp_pkg::Gif87a) ||
                      (w9[gfdp_pkg::HdrLen-1:0] == gfdp_pkg::Gif89a);
  assign hdr_eff    = header_checked ? header_ok : hdr_now;
  assign marker_hit = (w9[3:0] == gfdp_pkg::GceMarker) &&
                      (w9[gfdp_pkg::WinLen-1] == gfdp_pkg::GceTerm);
  assign delay      = {w9[6], w9[5]};
  assign hit        = full && hdr_eff && !scan_stopped && marker_hit;
  assign over       = delay > min_delay;

  always_comb begin
    p9  = w9;
    pm9 = m9;
    if (hit && !over) begin
      p9[5]  = replacement_delay[7:0];
      p9[6]  = replacement_delay[15:8];
      pm9[5] = 1'b1;
      pm9[6] = 1'b1;
    end
  end

  // Full window sends the oldest byte; the last beat sends held bytes and itself
  always_comb begin
    for (int j = 0; j < gfdp_pkg::WinLen; j++) begin
      burst.beats[j].data    = p9[j];
      burst.beats[j].patched = pm9[j];
      burst.beats[j].last    = last_byte && (gfdp_pkg::FillW'(j) == fill);
    end
    if (!accept) begin
      burst.count = '0;
    end else if (last_byte) begin
      burst.count = fill + gfdp_pkg::FillW'(1);
    end else if (full) begin
      burst.count = gfdp_pkg::FillW'(1);
    end else begin
      burst.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      header_ok      <= 1'b0;
      header_checked <= 1'b0;
      scan_stopped   <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        fill           <= '0;
        header_ok      <= 1'b0;
        header_checked <= 1'b0;
        scan_stopped   <= 1'b0;
      end else begin
        if (!full) begin
          fill <= fill + gfdp_pkg::FillW'(1);
        end
        if (!header_checked && fill >= gfdp_pkg::FillW'(gfdp_pkg::HdrLen - 1)) begin
          header_checked <= 1'b1;
          header_ok      <= hdr_now;
        end
        if (hit && over) begin
          scan_stopped <= 1'b1;
        end
      end
    end
  end

  // Held bytes: shift on a full window, otherwise append
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      if (full) begin
        win  <= p9[gfdp_pkg::WinLen-1:1];
        mark <= pm9[gfdp_pkg::WinLen-1:1];
      end else begin
        win[fill[2:0]]  <= data_byte;
        mark[fill[2:0]] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/gfdp_queue.sv
// ----------------------------------------------------------------------------
// gfdp_queue
// Result queue: up to a full window in, one beat a cycle out unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module gfdp_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  gfdp_pkg::burst_t                  burst,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output gfdp_pkg::beat_t                   head,
  output logic [gfdp_pkg::QLevelW-1:0]      level
);

  gfdp_pkg::beat_t [gfdp_pkg::QDepth-1:0] q;
  logic                                   pop;
  logic                                   push;
  logic                                   keep_head;

  assign out_valid = (level != '0);
  assign head      = q[0];
  assign pop       = out_valid && !out_stall;
  assign push      = (burst.count != '0);
  // A push only arrives with at most one beat queued
  assign keep_head = (level == gfdp_pkg::QLevelW'(1)) && !pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level - gfdp_pkg::QLevelW'(pop) + gfdp_pkg::QLevelW'(burst.count);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (keep_head) begin
        for (int i = 1; i < gfdp_pkg::QDepth; i++) begin
          q[i] <= burst.beats[i-1];
        end
      end else begin
        for (int i = 0; i < gfdp_pkg::WinLen; i++) begin
          q[i] <= burst.beats[i];
        end
      end
    end else if (pop) begin
      for (int i = 0; i < gfdp_pkg::QDepth - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

endmodule

`default_nettype wire
